/* rtl/mfba_pkg.sv */
package mfba_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int CAP_WIDTH_DEF    = 16;
    localparam int VCOUNT_W         = 5;
    localparam int ROW_W            = 4;
    localparam int CAPIN_W          = 16;
    localparam int TOTAL_W          = 20;

    // datapath command codes
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_WRITE,      // store one capacity entry
        CMD_CLR_STEP,   // clear flow entry at sweep address
        CMD_BFS_INIT,   // set visited and frontier to the source, clear next frontier
        CMD_BFS_READ,   // read residual at (u, v)
        CMD_BFS_LEVEL,  // frontier <= next frontier
        CMD_BN_READ,    // read residual along path
        CMD_AUG_FWD,    // flow[p][v] += bottleneck
        CMD_AUG_REV,    // flow[v][p] -= bottleneck
        CMD_SUM_READ,   // read flow[0][v]
        CMD_CAP_CLR     // clear capacity entry at sweep address
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic bn_init;
        logic sum_init;
    } ctrl_t;

    typedef struct packed {
        logic sink_found;   // visited[n-1]
        logic frontier_any; // frontier non-empty
        logic at_source;    // parent of the path walk vertex is vertex 0
    } stat_t;

endpackage

/* rtl/max_flow_bfs_augment_core.sv */
// max flow core, edmonds-karp over a 16x16 capacity matrix
// entries are taken one per cycle while idle; after the last entry the core clears flow,
//   runs the searches and augmentations, sums flow out of vertex 0 and clears capacity
// one request at a time, busy high for the whole computation
// done is high for a single cycle with the result on flow_value; the receiver cannot stall
// reset (rst_n low, async): vertex_count 16, then a capacity clear with busy high
module max_flow_bfs_augment_core #(
    parameter int MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF,
    parameter int CAP_WIDTH    = mfba_pkg::CAP_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mfba_pkg::ROW_W-1:0]         row_vertex,
    input  logic [mfba_pkg::ROW_W-1:0]         col_vertex,
    input  logic [mfba_pkg::CAPIN_W-1:0]       capacity,
    input  logic                               last,
    output logic                               done,
    output logic [mfba_pkg::TOTAL_W-1:0]       flow_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mfba_pkg::VCOUNT_W-1:0]      cfg_data
);
    localparam int VW = $clog2(MAX_VERTICES);

    mfba_pkg::ctrl_t ctrl;
    mfba_pkg::stat_t stat;
    logic [VW-1:0]   addr_u, addr_v, walk_sel, sink, parent_of_walk;
    logic [mfba_pkg::VCOUNT_W-1:0] vcount_reg;
    logic            in_ok;

    // vertex count register, writable only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vcount_reg <= mfba_pkg::VCOUNT_W'(16);
        else if (cfg_valid && cfg_ready) vcount_reg <= cfg_data;
    end
    assign cfg_ready = !busy;

    // clamp to [2, MAX_VERTICES], sink is n-1
    always_comb
    begin
        if (vcount_reg < 5'd2) sink = VW'(1);
        else if (32'(vcount_reg) > MAX_VERTICES) sink = VW'(MAX_VERTICES - 1);
        else sink = VW'(vcount_reg - 1'b1);
    end

    // entries outside the store are dropped
    assign in_ok = (32'(row_vertex) < MAX_VERTICES) && (32'(col_vertex) < MAX_VERTICES);

    mfba_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last(last),
        .in_row(VW'(row_vertex)), .in_col(VW'(col_vertex)), .in_ok(in_ok),
        .sink(sink), .parent_of_walk(parent_of_walk), .stat(stat),
        .ctrl(ctrl), .addr_u(addr_u), .addr_v(addr_v), .walk_sel(walk_sel),
        .busy(busy), .done(done)
    );

    // parent lookup of the path walk vertex comes back from the datapath
    mfba_datapath #(.MAX_VERTICES(MAX_VERTICES), .CAP_WIDTH(CAP_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .addr_u(addr_u), .addr_v(addr_v),
        .sink(sink), .wr_cap(CAP_WIDTH'(capacity)), .walk_sel(walk_sel),
        .stat(stat), .walk_parent(parent_of_walk), .total(flow_value)
    );

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> busy) else $error("last not started");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
endmodule

/* rtl/mfba_datapath.sv */
module mfba_datapath #(
    parameter int MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF,
    parameter int CAP_WIDTH    = mfba_pkg::CAP_WIDTH_DEF,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mfba_pkg::ctrl_t               ctrl,
    input  logic [VW-1:0]                 addr_u,
    input  logic [VW-1:0]                 addr_v,
    input  logic [VW-1:0]                 sink,
    input  logic [CAP_WIDTH-1:0]          wr_cap,
    input  logic [VW-1:0]                 walk_sel,
    output mfba_pkg::stat_t               stat,
    output logic [VW-1:0]                 walk_parent,
    output logic [mfba_pkg::TOTAL_W-1:0]  total
);
    localparam int AW = 2 * VW;
    localparam int FW = CAP_WIDTH + 2;

    logic [CAP_WIDTH-1:0]    cap_mem [2**AW];
    logic signed [FW-1:0]    flow_mem [2**AW];
    logic [MAX_VERTICES-1:0] visited_reg, frontier_reg, nfront_reg;
    logic [VW-1:0]           parent_reg [MAX_VERTICES];
    logic signed [FW-1:0]    bn_reg;
    logic [mfba_pkg::TOTAL_W-1:0] total_reg;

    logic [CAP_WIDTH-1:0]    cap_rd;
    logic signed [FW-1:0]    flow_rd;
    mfba_pkg::cmd_t          cmd_d;
    logic [VW-1:0]           u_d, v_d;
    logic [AW-1:0]           a_fwd;
    logic signed [FW:0]      resid;

    assign a_fwd = {addr_u, addr_v};
    assign resid = $signed({3'b000, cap_rd}) - (FW+1)'(flow_rd);

    // memory ports
    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            mfba_pkg::CMD_WRITE:    cap_mem[a_fwd] <= wr_cap;
            mfba_pkg::CMD_CLR_STEP: flow_mem[a_fwd] <= '0;
            mfba_pkg::CMD_CAP_CLR:  cap_mem[a_fwd] <= '0;
            mfba_pkg::CMD_AUG_FWD:  flow_mem[a_fwd] <= flow_rd + bn_reg;
            mfba_pkg::CMD_AUG_REV:  flow_mem[a_fwd] <= flow_rd - bn_reg;
            default: ;
        endcase
        cap_rd  <= cap_mem[a_fwd];
        flow_rd <= flow_mem[a_fwd];
        u_d     <= addr_u;
        v_d     <= addr_v;
    end

    // read operations resolve in the cycle after issue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_d        <= mfba_pkg::CMD_NOP;
            visited_reg  <= '0;
            frontier_reg <= '0;
            nfront_reg   <= '0;
            bn_reg       <= '0;
            total_reg    <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) parent_reg[i] <= '0;
        end
        else
        begin
            cmd_d <= ctrl.cmd;
            if (ctrl.bn_init) bn_reg <= {1'b0, {(FW-1){1'b1}}};
            if (ctrl.sum_init) total_reg <= '0;
            case (ctrl.cmd)
                mfba_pkg::CMD_BFS_INIT:
                begin
                    visited_reg  <= MAX_VERTICES'(1);
                    frontier_reg <= MAX_VERTICES'(1);
                    nfront_reg   <= '0;
                end
                mfba_pkg::CMD_BFS_LEVEL:
                begin
                    frontier_reg <= nfront_reg;
                    nfront_reg   <= '0;
                end
                default: ;
            endcase
            case (cmd_d)
                mfba_pkg::CMD_BFS_READ:
                    if (frontier_reg[u_d] && !visited_reg[v_d] && resid > 0)
                    begin
                        visited_reg[v_d] <= 1'b1;
                        nfront_reg[v_d]  <= 1'b1;
                        parent_reg[v_d]  <= u_d;
                    end
                mfba_pkg::CMD_BN_READ:
                    if (resid < (FW+1)'(bn_reg)) bn_reg <= resid[FW-1:0];
                mfba_pkg::CMD_SUM_READ:
                    total_reg <= total_reg + mfba_pkg::TOTAL_W'(flow_rd);
                default: ;
            endcase
        end
    end

    assign walk_parent       = parent_reg[walk_sel];
    assign stat.sink_found   = visited_reg[sink];
    assign stat.frontier_any = |frontier_reg;
    assign stat.at_source    = (walk_parent == '0);
    assign total             = total_reg;
endmodule

/* rtl/mfba_ctrl.sv */
module mfba_ctrl #(
    parameter int MAX_VERTICES = mfba_pkg::MAX_VERTICES_DEF,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            last,
    input  logic [VW-1:0]   in_row,
    input  logic [VW-1:0]   in_col,
    input  logic            in_ok,
    input  logic [VW-1:0]   sink,
    input  logic [VW-1:0]   parent_of_walk,
    input  mfba_pkg::stat_t stat,
    output mfba_pkg::ctrl_t ctrl,
    output logic [VW-1:0]   addr_u,
    output logic [VW-1:0]   addr_v,
    output logic [VW-1:0]   walk_sel,
    output logic            busy,
    output logic            done
);
    typedef enum logic [3:0] {
        S_RCLR, S_IDLE, S_FCLR, S_BINIT, S_BCHK, S_BSCAN, S_BWAIT, S_BLVL,
        S_BN, S_AFWD, S_AREV, S_SUM, S_SUMW, S_CCLR, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [2*VW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]   wv_reg, wv_next;
    logic [1:0]      ph_reg, ph_next;
    logic            cnt_end;

    assign cnt_end = cnt_reg == '1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wv_next    = wv_reg;
        ph_next    = ph_reg;
        ctrl       = '{cmd: mfba_pkg::CMD_NOP, bn_init: 1'b0, sum_init: 1'b0};
        addr_u     = cnt_reg[2*VW-1:VW];
        addr_v     = cnt_reg[VW-1:0];
        unique case (state_reg)
            S_RCLR:
            begin
                // capacity memory clear after reset
                ctrl.cmd = mfba_pkg::CMD_CAP_CLR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) state_next = S_IDLE;
            end
            S_IDLE:
                if (start)
                begin
                    addr_u = in_row;
                    addr_v = in_col;
                    if (in_ok) ctrl.cmd = mfba_pkg::CMD_WRITE;
                    if (last)
                    begin
                        state_next = S_FCLR;
                        cnt_next   = '0;
                    end
                end
            S_FCLR:
            begin
                ctrl.cmd = mfba_pkg::CMD_CLR_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) state_next = S_BINIT;
            end
            S_BINIT:
            begin
                ctrl.cmd   = mfba_pkg::CMD_BFS_INIT;
                state_next = S_BCHK;
            end
            S_BCHK:
                if (stat.sink_found)
                begin
                    state_next   = S_BN;
                    wv_next      = sink;
                    ctrl.bn_init = 1'b1;
                end
                else if (!stat.frontier_any)
                begin
                    state_next    = S_SUM;
                    cnt_next      = '0;
                    ctrl.sum_init = 1'b1;
                end
                else
                begin
                    state_next = S_BSCAN;
                    cnt_next   = '0;
                end
            S_BSCAN:
            begin
                // u descending for highest-numbered parent
                addr_u = ~cnt_reg[2*VW-1:VW];
                if (cnt_reg[VW-1:0] <= sink && ~cnt_reg[2*VW-1:VW] <= sink)
                    ctrl.cmd = mfba_pkg::CMD_BFS_READ;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) state_next = S_BWAIT;
            end
            S_BWAIT:
                // last scan read resolves here
                state_next = S_BLVL;
            S_BLVL:
            begin
                ctrl.cmd   = mfba_pkg::CMD_BFS_LEVEL;
                state_next = S_BCHK;
            end
            S_BN:
            begin
                // read residual(parent, wv) in phase 0, step to the parent in phase 1
                addr_u = parent_of_walk;
                addr_v = wv_reg;
                if (ph_reg == 2'd0)
                begin
                    ctrl.cmd = mfba_pkg::CMD_BN_READ;
                    ph_next  = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    wv_next = parent_of_walk;
                    if (stat.at_source)
                    begin
                        wv_next    = sink;
                        state_next = S_AFWD;
                    end
                end
            end
            S_AFWD:
            begin
                addr_u = parent_of_walk;
                addr_v = wv_reg;
                // phase 0 reads, phase 1 writes
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd1) ctrl.cmd = mfba_pkg::CMD_AUG_FWD;
                if (ph_reg == 2'd1)
                begin
                    ph_next    = 2'd0;
                    state_next = S_AREV;
                end
            end
            S_AREV:
            begin
                addr_u  = wv_reg;
                addr_v  = parent_of_walk;
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd1)
                begin
                    ctrl.cmd   = mfba_pkg::CMD_AUG_REV;
                    ph_next    = 2'd0;
                    wv_next    = parent_of_walk;
                    state_next = stat.at_source ? S_BINIT : S_AFWD;
                end
            end
            S_SUM:
            begin
                addr_u = '0;
                if (cnt_reg[VW-1:0] <= sink) ctrl.cmd = mfba_pkg::CMD_SUM_READ;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[VW-1:0] == '1) state_next = S_SUMW;
            end
            S_SUMW:
            begin
                cnt_next   = '0;
                state_next = S_CCLR;
            end
            S_CCLR:
            begin
                ctrl.cmd = mfba_pkg::CMD_CAP_CLR;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RCLR;
            cnt_reg   <= '0;
            wv_reg    <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wv_reg    <= wv_next;
            ph_reg    <= ph_next;
        end
    end

    assign walk_sel = wv_reg;
    assign busy     = state_reg != S_IDLE;
    assign done     = state_reg == S_DONE;
endmodule
